/* rtl/afr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the frame receiver
// Holds the byte codes, outcome codes, register indexes and the frame event.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam logic [7:0] StartMark = 8'h7E;
    localparam logic [7:0] ApiRx16   = 8'h81;
    localparam logic [7:0] SumGood   = 8'hFF;
    localparam logic [7:0] FuelReset = 8'hFF;

    localparam int SumBytes = 12;
    localparam int PosApi   = 0;
    localparam int PosMsgId = 5;
    localparam int PosFuel  = 6;

    localparam logic [1:0] OutcomeDrop   = 2'd0;
    localparam logic [1:0] OutcomePair   = 2'd1;
    localparam logic [1:0] OutcomeStatus = 2'd2;

    localparam logic [1:0] CfgPairAckId = 2'd0;
    localparam logic [1:0] CfgStatusId  = 2'd1;

    typedef struct packed {
        logic [7:0] api;
        logic [7:0] msg_id;
        logic [7:0] fuel;
        logic [7:0] sum;
    } afr_event_t;

endpackage

`default_nettype wire

/* rtl/afr_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_parser: frame parser
// Tracks the start mark, the length and the frame bytes, keeps the first
// bytes of each frame with a running checksum, and signals the frame end.
// ----------------------------------------------------------------------------
module afr_parser
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         rx_byte,
    output logic                    evt_fire,
    output afr_pkg::afr_event_t     evt
);
    import afr_pkg::*;

    localparam logic [1:0] PhIdle  = 2'd0;
    localparam logic [1:0] PhLenHi = 2'd1;
    localparam logic [1:0] PhLenLo = 2'd2;
    localparam logic [1:0] PhData  = 2'd3;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [7:0]  len_hi_reg;
    logic [7:0]  len_hi_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [7:0]  store_reg [SumBytes];
    logic [7:0]  store_next [SumBytes];
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [7:0]  old_byte;
    logic        wr_en;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_hi_next = len_hi_reg;
        len_next    = len_reg;
        evt_fire    = 1'b0;
        wr_en       = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PhIdle:
                begin
                    if (rx_byte == StartMark)
                    begin
                        phase_next = PhLenHi;
                    end
                end
                PhLenHi:
                begin
                    len_hi_next = rx_byte;
                    phase_next  = PhLenLo;
                end
                PhLenLo:
                begin
                    len_next   = {len_hi_reg, rx_byte};
                    count_next = 16'd0;
                    phase_next = PhData;
                end
                default:
                begin
                    wr_en = (count_reg < 16'(SumBytes));
                    if (count_reg != len_reg)
                    begin
                        count_next = count_reg + 16'd1;
                    end
                    else
                    begin
                        phase_next = PhIdle;
                        count_next = 16'd0;
                        evt_fire   = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        old_byte = 8'd0;
        for (int i = 0; i < SumBytes; i++)
        begin
            store_next[i] = store_reg[i];
            if (wr_en && (count_reg == 16'(i)))
            begin
                old_byte      = store_reg[i];
                store_next[i] = rx_byte;
            end
        end
        sum_next = wr_en ? (sum_reg - old_byte + rx_byte) : sum_reg;
    end

    assign evt.api    = store_next[PosApi];
    assign evt.msg_id = store_next[PosMsgId];
    assign evt.fuel   = store_next[PosFuel];
    assign evt.sum    = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PhIdle;
            count_reg  <= 16'd0;
            len_hi_reg <= 8'd0;
            len_reg    <= 16'd0;
            sum_reg    <= 8'd0;
            for (int i = 0; i < SumBytes; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            len_hi_reg <= len_hi_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            for (int i = 0; i < SumBytes; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/afr_judge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_judge: frame check and result register
// Registers each frame end, checks the API byte, the message id and the
// checksum, keeps the fuel byte and holds the result until it is taken.
// ----------------------------------------------------------------------------
module afr_judge
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                evt_fire,
    input  wire afr_pkg::afr_event_t evt,
    input  wire logic [7:0]          pair_ack_id,
    input  wire logic [7:0]          status_id,
    input  wire logic                out_stall,
    output logic                     busy,
    output logic                     out_valid,
    output logic [1:0]               outcome,
    output logic [7:0]               fuel_level
);
    import afr_pkg::*;

    logic       evt_valid_reg;
    afr_event_t evt_reg;
    logic       out_valid_reg;
    logic [1:0] outcome_reg;
    logic [1:0] outcome_next;
    logic [7:0] fuel_reg;
    logic [7:0] fuel_next;
    logic       advance;
    logic       sum_ok;

    assign advance = evt_valid_reg && (!out_valid_reg || !out_stall);
    assign busy    = evt_valid_reg && !advance;
    assign sum_ok  = (evt_reg.sum == SumGood);

    always_comb
    begin
        outcome_next = OutcomeDrop;
        fuel_next    = fuel_reg;
        if (evt_reg.api == ApiRx16)
        begin
            if (evt_reg.msg_id == pair_ack_id)
            begin
                outcome_next = sum_ok ? OutcomePair : OutcomeDrop;
            end
            else if ((evt_reg.msg_id == status_id) && sum_ok)
            begin
                outcome_next = OutcomeStatus;
                fuel_next    = evt_reg.fuel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            evt_reg <= evt;
        end
        if (advance)
        begin
            outcome_reg <= outcome_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fuel_reg      <= FuelReset;
        end
        else
        begin
            if (evt_fire)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                evt_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                fuel_reg      <= fuel_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign outcome    = outcome_reg;
    assign fuel_level = fuel_reg;

endmodule

`default_nettype wire

/* rtl/api_frame_receiver_checksum.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_receiver_checksum: serial frame receiver with 8-bit checksum
// Finds frames in a byte stream, checks them and reports one result per
// frame, keeping the fuel byte of the last valid status message.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    rx_byte
// result    out        out_valid/out_stall  outcome, fuel_level
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken in every cycle while the result path is free.
// A result passes the frame-end register, then the result register, after its frame's last byte is taken.
// A frame-end item waits in one register behind the result register, so
// input stalls only when both are full and the result is stalled.
// Reset clears the parser, the stored bytes and sets the fuel byte to 255.
// ----------------------------------------------------------------------------
module api_frame_receiver_checksum
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      outcome,
    output logic [7:0]      fuel_level,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import afr_pkg::*;

    logic       accept;
    logic       evt_fire;
    afr_event_t evt;
    logic       busy;
    logic [7:0] pair_ack_id_reg;
    logic [7:0] status_id_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign accept    = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_ack_id_reg <= 8'd0;
            status_id_reg   <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgPairAckId: pair_ack_id_reg <= cfg_data;
                CfgStatusId:  status_id_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    afr_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .evt_fire (evt_fire),
        .evt      (evt)
    );

    afr_judge u_judge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_fire    (evt_fire),
        .evt         (evt),
        .pair_ack_id (pair_ack_id_reg),
        .status_id   (status_id_reg),
        .out_stall   (out_stall),
        .busy        (busy),
        .out_valid   (out_valid),
        .outcome     (outcome),
        .fuel_level  (fuel_level)
    );

endmodule

`default_nettype wire

/* rtl/afr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_checker: port checks of the frame receiver
// Watches the top-level ports for result and stall behavior over time.
// ----------------------------------------------------------------------------
module afr_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] outcome,
    input wire logic [7:0] fuel_level
);
    import afr_pkg::*;

    // A stalled result holds its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(fuel_level))
        else $error("stalled result changed");

    // Only defined outcome codes are delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome == OutcomeDrop || outcome == OutcomePair
                       || outcome == OutcomeStatus))
        else $error("undefined outcome code");

    // Input stalls only while a result waits on a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result path");

    // A new result must be preceded by an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a preceding item");

endmodule

bind api_frame_receiver_checksum afr_checker u_afr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .outcome    (outcome),
    .fuel_level (fuel_level)
);

`default_nettype wire
